// File: design/per_pixel_phase_biquad_filter_core_defines.svh
// Assertion macros shared by the phase biquad filter core.
`ifndef PER_PIXEL_PHASE_BIQUAD_FILTER_CORE_DEFINES_SVH
`define PER_PIXEL_PHASE_BIQUAD_FILTER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PPBQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define PPBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ppbq_pkg.sv
// Types, constants and helpers of the phase biquad filter core.
package ppbq_pkg;

    localparam int DEF_PIXEL_COUNT    = 65536;
    localparam int DEF_COEF_FRAC_BITS = 14;

    localparam int PIXEL_ADDR_W = 16;
    localparam int SAMPLE_W     = 16;
    localparam int WORD_W       = 32;
    localparam int COEF_W       = 18;
    localparam int PROD_W       = WORD_W + COEF_W;
    localparam int SUM_W        = PROD_W + 4;

    // Stages between the state read and the write back in a lane.
    localparam int LANE_LAT  = 5;
    // Result queue depth, also the limit on transactions in flight.
    localparam int OUT_DEPTH = 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 18'sd16384;

    // Input operations.
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coef;

    typedef struct packed {
        logic signed [WORD_W-1:0] acc;
        logic signed [WORD_W-1:0] d1;
        logic signed [WORD_W-1:0] d2;
    } t_state;

    typedef struct packed {
        logic en;
        logic zero;
    } t_wr_ctl;

    typedef struct packed {
        logic        [PIXEL_ADDR_W-1:0] pixel_out_addr;
        logic signed [WORD_W-1:0]       out_cos;
        logic signed [WORD_W-1:0]       out_sin;
    } t_result;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[WORD_W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[WORD_W-1:0];
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/per_pixel_phase_biquad_filter_core.sv
// Top level of the per-pixel phase unwrap and biquad filter core.
//
// Input channel (i_valid / o_ready): one transaction per pixel sample with
// an op, a flat pixel address and a cosine and sine phase difference. A
// filter op adds each difference to the pixel's phase accumulator and runs
// the sum through a transposed direct-form-II biquad; a clear op zeroes the
// pixel's state. Output channel (o_valid / i_ready): one transaction per
// input transaction, in order, carrying the echoed address and both
// filtered values (zero after a clear or for an address past PIXEL_COUNT).
// The result passes through a registered state read, four pipeline stages
// and a queue write before it is presented. Throughput: one transaction
// per cycle unless an address hazard, the credit limit or the clearing
// pass holds o_ready low. The read-modify-write loop through the state
// memory is five stages long, so a transaction whose address matches one
// still in those stages waits for its write back. At most OUT_DEPTH
// transactions are in flight; when the receiver stalls, results collect in
// the queue and o_ready drops once it would fill. Reset: coefficients
// return to b0 = 1.0 and others 0, then a clearing pass writes zero to
// every state entry, one per cycle; o_ready stays low during that pass.
// Coefficient writes over the APB port are taken at any time.
`include "per_pixel_phase_biquad_filter_core_defines.svh"

module per_pixel_phase_biquad_filter_core #(
    parameter int PIXEL_COUNT    = ppbq_pkg::DEF_PIXEL_COUNT,
    parameter int COEF_FRAC_BITS = ppbq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Input channel
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic                                     i_op,
    input  logic [ppbq_pkg::PIXEL_ADDR_W-1:0]        i_pixel_addr,
    input  logic signed [ppbq_pkg::SAMPLE_W-1:0]     i_diff_cos,
    input  logic signed [ppbq_pkg::SAMPLE_W-1:0]     i_diff_sin,
    // Output channel
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [ppbq_pkg::PIXEL_ADDR_W-1:0]        o_pixel_out_addr,
    output logic signed [ppbq_pkg::WORD_W-1:0]       o_out_cos,
    output logic signed [ppbq_pkg::WORD_W-1:0]       o_out_sin,
    // Configuration port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [ppbq_pkg::CFG_ADDR_W-1:0]          paddr,
    input  logic [ppbq_pkg::CFG_DATA_W-1:0]          pwdata,
    output logic [ppbq_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import ppbq_pkg::*;

    localparam int ADDR_SPAN = 1 << PIXEL_ADDR_W;
    localparam int MEM_DEPTH = (PIXEL_COUNT < ADDR_SPAN) ? PIXEL_COUNT : ADDR_SPAN;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LAST      = LANE_LAT - 1;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    t_coef                r_coef;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_wr;

    assign w_reg_idx = paddr[CFG_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b0 <= COEF_B0_RESET;
            r_coef.b1 <= '0;
            r_coef.b2 <= '0;
            r_coef.a1 <= '0;
            r_coef.a2 <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_B0:  r_coef.b0 <= pwdata[COEF_W-1:0];
                REG_B1:  r_coef.b1 <= pwdata[COEF_W-1:0];
                REG_B2:  r_coef.b2 <= pwdata[COEF_W-1:0];
                REG_A1:  r_coef.a1 <= pwdata[COEF_W-1:0];
                REG_A2:  r_coef.a2 <= pwdata[COEF_W-1:0];
                default: r_coef    <= r_coef;
            endcase
        end
    end

    // Read back sign-extended.
    always_comb begin
        unique case (w_reg_idx)
            REG_B0:  prdata = CFG_DATA_W'($signed(r_coef.b0));
            REG_B1:  prdata = CFG_DATA_W'($signed(r_coef.b1));
            REG_B2:  prdata = CFG_DATA_W'($signed(r_coef.b2));
            REG_A1:  prdata = CFG_DATA_W'($signed(r_coef.a1));
            REG_A2:  prdata = CFG_DATA_W'($signed(r_coef.a2));
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + ADDR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Admission: address interlock and result credit
    // ------------------------------------------------------------------
    logic                    r_v    [LANE_LAT];
    logic [PIXEL_ADDR_W-1:0] r_addr [LANE_LAT];
    logic                    r_op   [LANE_LAT];
    logic                    r_inr  [LANE_LAT];
    logic [CNT_W-1:0]        r_outstanding;

    logic w_hazard, w_accept, w_deliver, w_in_range;

    // Hold any address still on its way to write back; the write at the
    // end of the last stage lands on the same edge as a new read.
    always_comb begin
        w_hazard = 1'b0;
        for (int k = 0; k < LANE_LAT; k++) begin
            if (r_v[k] && (r_addr[k] == i_pixel_addr)) begin
                w_hazard = 1'b1;
            end
        end
    end

    assign o_ready    = !r_clr_busy && !w_hazard && (r_outstanding < CNT_W'(OUT_DEPTH));
    assign w_accept   = i_valid && o_ready;
    assign w_deliver  = o_valid && i_ready;
    assign w_in_range = (32'(i_pixel_addr) < 32'(PIXEL_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({w_accept, w_deliver})
                2'b10:   r_outstanding <= r_outstanding + CNT_W'(1);
                2'b01:   r_outstanding <= r_outstanding - CNT_W'(1);
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    // Control pipeline alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= w_accept;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr[0] <= i_pixel_addr;
        r_op[0]   <= i_op;
        r_inr[0]  <= w_in_range;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_addr[k] <= r_addr[k-1];
            r_op[k]   <= r_op[k-1];
            r_inr[k]  <= r_inr[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------
    t_wr_ctl                  w_wr;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic [ADDR_W-1:0]        w_rd_addr;
    logic signed [WORD_W-1:0] w_y_cos, w_y_sin;

    // Sweep writes take the port while no transaction can be in flight.
    always_comb begin
        w_wr.en   = r_clr_busy || (r_v[LAST] && r_inr[LAST]);
        w_wr.zero = r_clr_busy || (r_op[LAST] == OP_CLEAR);
        w_wr_addr = r_clr_busy ? r_clr_idx : r_addr[LAST][ADDR_W-1:0];
    end

    assign w_rd_addr = i_pixel_addr[ADDR_W-1:0];

    ppbq_lane #(
        .DEPTH          (MEM_DEPTH),
        .ADDR_W         (ADDR_W),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_cos (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .i_diff    (i_diff_cos),
        .i_coef    (r_coef),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .o_y       (w_y_cos)
    );

    ppbq_lane #(
        .DEPTH          (MEM_DEPTH),
        .ADDR_W         (ADDR_W),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_sin (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .i_diff    (i_diff_sin),
        .i_coef    (r_coef),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .o_y       (w_y_sin)
    );

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    t_result w_push_data, w_head;
    logic    w_live;

    // Drop the filter value for clears and out-of-range addresses.
    always_comb begin
        w_live                     = r_inr[LAST] && (r_op[LAST] == OP_FILTER);
        w_push_data.pixel_out_addr = r_addr[LAST];
        w_push_data.out_cos        = w_live ? w_y_cos : '0;
        w_push_data.out_sin        = w_live ? w_y_sin : '0;
    end

    ppbq_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v[LAST]),
        .i_data  (w_push_data),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (w_head)
    );

    assign o_pixel_out_addr = w_head.pixel_out_addr;
    assign o_out_cos        = w_head.out_cos;
    assign o_out_sin        = w_head.out_sin;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PPBQ_ASSERT_ALWAYS(a_credit_bound, r_outstanding <= CNT_W'(OUT_DEPTH), "credit overrun")
    `PPBQ_ASSERT_ALWAYS(a_no_accept_in_sweep, r_clr_busy |-> !o_ready, "accept during clear pass")
    `PPBQ_ASSERT_ALWAYS(a_idle_no_result, (r_outstanding == '0) |-> !o_valid, "result without credit")
    `PPBQ_ASSERT_NEXT(a_sweep_ends, r_clr_busy && (r_clr_idx == CLR_LAST), !r_clr_busy, "clear pass overrun")

endmodule

// File: design/ppbq_lane.sv
// One component lane: state memory, unwrap accumulator and biquad pipeline.
module ppbq_lane #(
    parameter int DEPTH          = ppbq_pkg::DEF_PIXEL_COUNT,
    parameter int ADDR_W         = 16,
    parameter int COEF_FRAC_BITS = ppbq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rd_en,
    input  logic [ADDR_W-1:0]                     i_rd_addr,
    input  logic signed [ppbq_pkg::SAMPLE_W-1:0]  i_diff,
    input  ppbq_pkg::t_coef                       i_coef,
    input  ppbq_pkg::t_wr_ctl                     i_wr,
    input  logic [ADDR_W-1:0]                     i_wr_addr,
    output logic signed [ppbq_pkg::WORD_W-1:0]    o_y
);
    import ppbq_pkg::*;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

    t_state r_mem [DEPTH];

    // Stage 1: state word and difference.
    t_state                    r_rd;
    logic signed [SAMPLE_W-1:0] r_diff1;
    // Stage 2: unwrapped phase.
    logic signed [WORD_W-1:0]  r_acc2, r_d1_2, r_d2_2;
    // Stage 3: feedforward products.
    logic signed [PROD_W-1:0]  r_p0_3, r_p1_3, r_p2_3;
    logic signed [WORD_W-1:0]  r_acc3, r_d1_3, r_d2_3;
    // Stage 4: filter output.
    logic signed [WORD_W-1:0]  r_y4, r_acc4, r_d2_4;
    logic signed [PROD_W-1:0]  r_p1_4, r_p2_4;
    // Stage 5: feedback products.
    logic signed [WORD_W-1:0]  r_y5, r_acc5, r_d2_5;
    logic signed [PROD_W-1:0]  r_p1_5, r_p2_5, r_q1_5, r_q2_5;

    logic signed [WORD_W-1:0]  n_acc2, n_y4, n_d1, n_d2;
    logic signed [SUM_W-1:0]   w_y_sum, w_y_rnd, w_d1_sum, w_d1_rnd, w_d2_sum, w_d2_rnd;
    t_state                    n_wdata;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd    <= r_mem[i_rd_addr];
            r_diff1 <= i_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= n_wdata;
        end
    end

    always_comb begin
        n_acc2   = sat_word(SUM_W'($signed(r_rd.acc)) + SUM_W'(r_diff1));

        w_y_sum  = SUM_W'(r_p0_3) + RND_HALF;
        w_y_rnd  = w_y_sum >>> COEF_FRAC_BITS;
        n_y4     = sat_word(w_y_rnd + SUM_W'(r_d1_3));

        w_d1_sum = SUM_W'(r_p1_5) - SUM_W'(r_q1_5) + RND_HALF;
        w_d1_rnd = w_d1_sum >>> COEF_FRAC_BITS;
        n_d1     = sat_word(w_d1_rnd + SUM_W'(r_d2_5));

        w_d2_sum = SUM_W'(r_p2_5) - SUM_W'(r_q2_5) + RND_HALF;
        w_d2_rnd = w_d2_sum >>> COEF_FRAC_BITS;
        n_d2     = sat_word(w_d2_rnd);

        if (i_wr.zero) begin
            n_wdata = '0;
        end else begin
            n_wdata.acc = r_acc5;
            n_wdata.d1  = n_d1;
            n_wdata.d2  = n_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc2 <= n_acc2;
        r_d1_2 <= $signed(r_rd.d1);
        r_d2_2 <= $signed(r_rd.d2);

        r_p0_3 <= r_acc2 * $signed(i_coef.b0);
        r_p1_3 <= r_acc2 * $signed(i_coef.b1);
        r_p2_3 <= r_acc2 * $signed(i_coef.b2);
        r_acc3 <= r_acc2;
        r_d1_3 <= r_d1_2;
        r_d2_3 <= r_d2_2;

        r_y4   <= n_y4;
        r_p1_4 <= r_p1_3;
        r_p2_4 <= r_p2_3;
        r_acc4 <= r_acc3;
        r_d2_4 <= r_d2_3;

        r_q1_5 <= r_y4 * $signed(i_coef.a1);
        r_q2_5 <= r_y4 * $signed(i_coef.a2);
        r_p1_5 <= r_p1_4;
        r_p2_5 <= r_p2_4;
        r_acc5 <= r_acc4;
        r_d2_5 <= r_d2_4;
        r_y5   <= r_y4;
    end

    assign o_y = r_y5;

endmodule

// File: design/ppbq_out_fifo.sv
// Result queue between the filter pipeline and the output channel.
module ppbq_out_fifo #(
    parameter int DEPTH = ppbq_pkg::OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ppbq_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output ppbq_pkg::t_result o_data
);
    import ppbq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_result           r_buf [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the per-pixel phase unwrap and biquad filter core.
`timescale 1ns / 100ps

module tb;
    import ppbq_pkg::*;

    // Run length and stimulus shape.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASE_ITEMS = 120;
    localparam int PHASES      = 6;
    localparam int DRAIN_WAIT  = 12;
    // Back-to-back single-pixel run at full-scale differences.
    localparam int                      PIN_STEPS = 60;
    localparam logic [PIXEL_ADDR_W-1:0] PIN_ADDR  = 16'h0F0F;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sh1FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 18'sh20000;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
    // Index past the end of the coefficient list; writes there are ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;

    localparam longint WORD_MAX = 2147483647;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam int     FRAC     = DEF_COEF_FRAC_BITS;

    // Per-pixel phase unwrap and biquad prediction, plus the queue of
    // results still owed by the block.
    class biquad_phase_tracker;
        longint b0, b1, b2, a1, a2;
        t_state cos_state[int];
        t_state sin_state[int];
        t_result due_results[$];
        int errors;
        int matched;

        function new();
            b0 = COEF_B0_RESET;
            b1 = 0;
            b2 = 0;
            a1 = 0;
            a2 = 0;
            errors = 0;
            matched = 0;
        endfunction

        function void set_coef(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            longint v;
            v = signed'(data[COEF_W-1:0]);
            case (idx)
                REG_B0: b0 = v;
                REG_B1: b1 = v;
                REG_B2: b2 = v;
                REG_A1: a1 = v;
                REG_A2: a2 = v;
                default: ;
            endcase
        endfunction

        function logic signed [WORD_W-1:0] clamp_word(longint x);
            if (x > WORD_MAX) return WORD_W'(WORD_MAX);
            if (x < WORD_MIN) return WORD_W'(WORD_MIN);
            return WORD_W'(x);
        endfunction

        // Round to nearest, ties toward plus infinity, then drop FRAC bits.
        function longint round_q(longint x);
            return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        endfunction

        function logic signed [WORD_W-1:0] filter_step(inout t_state s, input longint diff);
            longint acc;
            longint y;
            acc = clamp_word(longint'(s.acc) + diff);
            y = clamp_word(round_q(acc * b0) + s.d1);
            s.d1 = clamp_word(round_q(acc * b1 - y * a1) + s.d2);
            s.d2 = clamp_word(round_q(acc * b2 - y * a2));
            s.acc = WORD_W'(acc);
            return WORD_W'(y);
        endfunction

        function void note_pixel(logic op, logic [PIXEL_ADDR_W-1:0] addr,
                                 logic signed [SAMPLE_W-1:0] dc,
                                 logic signed [SAMPLE_W-1:0] ds);
            t_result r;
            t_state sc;
            t_state ss;
            int key;
            key = addr;
            r.pixel_out_addr = addr;
            r.out_cos = '0;
            r.out_sin = '0;
            if (key < DEF_PIXEL_COUNT) begin
                if (op == OP_CLEAR) begin
                    cos_state.delete(key);
                    sin_state.delete(key);
                end else begin
                    sc = cos_state.exists(key) ? cos_state[key] : '0;
                    ss = sin_state.exists(key) ? sin_state[key] : '0;
                    r.out_cos = filter_step(sc, dc);
                    r.out_sin = filter_step(ss, ds);
                    cos_state[key] = sc;
                    sin_state[key] = ss;
                end
            end
            due_results = {due_results, r};
        endfunction

        function void match_result(logic [PIXEL_ADDR_W-1:0] addr,
                                   logic signed [WORD_W-1:0] c,
                                   logic signed [WORD_W-1:0] s);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: pixel_out_addr %0d", addr);
                errors++;
                return;
            end
            want = due_results.pop_front();
            matched++;
            if (addr !== want.pixel_out_addr) begin
                $error("pixel_out_addr: expected %0d, actual %0d", want.pixel_out_addr, addr);
                errors++;
            end
            if (c !== want.out_cos) begin
                $error("out_cos: expected %0d, actual %0d", want.out_cos, c);
                errors++;
            end
            if (s !== want.out_sin) begin
                $error("out_sin: expected %0d, actual %0d", want.out_sin, s);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic                           i_op;
    logic [PIXEL_ADDR_W-1:0]        i_pixel_addr;
    logic signed [SAMPLE_W-1:0]     i_diff_cos;
    logic signed [SAMPLE_W-1:0]     i_diff_sin;
    logic                           o_valid;
    logic                           i_ready;
    logic [PIXEL_ADDR_W-1:0]        o_pixel_out_addr;
    logic signed [WORD_W-1:0]       o_out_cos;
    logic signed [WORD_W-1:0]       o_out_sin;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [CFG_ADDR_W-1:0]          paddr;
    logic [CFG_DATA_W-1:0]          pwdata;
    logic [CFG_DATA_W-1:0]          prdata;
    logic                           pready;

    biquad_phase_tracker tracker = new();

    // Disable random idling on both channels while set.
    bit steady = 1'b0;
    int cycles = 0;
    int sent = 0;
    int clears = 0;
    int settings = 0;

    per_pixel_phase_biquad_filter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_pixel_addr     (i_pixel_addr),
        .i_diff_cos       (i_diff_cos),
        .i_diff_sin       (i_diff_sin),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_out_addr (o_pixel_out_addr),
        .o_out_cos        (o_out_cos),
        .o_out_sin        (o_out_sin),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run; the limit covers the clearing pass after reset,
    // the single-pixel run with its address hazards and all random stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check each accepted transaction against the oldest
    // prediction, then pick the next ready value (about 22% stalls).
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                tracker.match_result(o_pixel_out_addr, o_out_cos, o_out_sin);
            end
            i_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    // Send one pixel transaction; optionally idle first, then hold valid and
    // payload until the block takes it, and log it with the predictor.
    task automatic send_pixel(input logic op, input logic [PIXEL_ADDR_W-1:0] addr,
                              input logic signed [SAMPLE_W-1:0] dc,
                              input logic signed [SAMPLE_W-1:0] ds);
        if (!steady && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 22);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_pixel_addr <= addr;
        i_diff_cos   <= dc;
        i_diff_sin   <= ds;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_pixel(op, addr, dc, ds);
        sent++;
        if (op == OP_CLEAR) clears++;
    endtask

    // Drop valid and hold until every predicted result has come back,
    // then let the pipeline go quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, done when pready is seen.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_coef(idx, data);
    endtask

    task automatic program_coefs(input logic signed [COEF_W-1:0] b0,
                                 input logic signed [COEF_W-1:0] b1,
                                 input logic signed [COEF_W-1:0] b2,
                                 input logic signed [COEF_W-1:0] a1,
                                 input logic signed [COEF_W-1:0] a2);
        write_reg(REG_B0, CFG_DATA_W'(b0));
        write_reg(REG_B1, CFG_DATA_W'(b1));
        write_reg(REG_B2, CFG_DATA_W'(b2));
        write_reg(REG_A1, CFG_DATA_W'(a1));
        write_reg(REG_A2, CFG_DATA_W'(a2));
        settings++;
    endtask

    // Mix of full-range, small and extreme phase differences.
    function automatic logic signed [SAMPLE_W-1:0] pick_diff();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        return COEF_W'($urandom);
    endfunction

    initial begin
        logic [PIXEL_ADDR_W-1:0] pool[8];
        logic [PIXEL_ADDR_W-1:0] addr;
        int roll;

        // Hold everything at a known value through reset.
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_op         <= OP_FILTER;
        i_pixel_addr <= '0;
        i_diff_cos   <= '0;
        i_diff_sin   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients pass the accumulator straight through, so these
        // expose the unwrap, the extremes and clears; the first transaction
        // waits out the clearing pass.
        send_pixel(OP_FILTER, 16'h0000, 16'sh7FFF, 16'sh8000);
        send_pixel(OP_FILTER, 16'h0000, 16'sh8000, 16'sh7FFF);
        send_pixel(OP_FILTER, 16'hFFFF, 16'sh5555, 16'shAAAA);
        send_pixel(OP_FILTER, 16'hFFFF, 16'shAAAA, 16'sh5555);
        send_pixel(OP_CLEAR, 16'h0000, 16'sh7FFF, 16'sh7FFF);
        send_pixel(OP_FILTER, 16'h0000, 16'sh0001, 16'shFFFF);
        send_pixel(OP_CLEAR, 16'h1234, 16'sh0000, 16'sh0000);
        send_pixel(OP_FILTER, 16'h1234, 16'shFFFF, 16'sh0001);
        send_pixel(OP_FILTER, 16'h8000, 16'sh0000, 16'sh0000);
        send_pixel(OP_FILTER, 16'h0000, 16'sh0000, 16'sh0000);
        settle();

        // Write past the register list (must be ignored), then load an
        // unstable extreme set so the output and delay words saturate.
        write_reg(REG_SPARE, $urandom);
        program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        repeat (8) send_pixel(OP_FILTER, 16'h0007, 16'sh7FFF, 16'sh8000);
        send_pixel(OP_CLEAR, 16'h0007, 16'sh1234, 16'sh4321);
        send_pixel(OP_FILTER, 16'h0007, 16'sh7FFF, 16'sh8000);
        send_pixel(OP_FILTER, 16'hFFFF, 16'sh8000, 16'sh7FFF);
        send_pixel(OP_FILTER, 16'hFFFF, 16'sh8000, 16'sh7FFF);

        // Random phases, each under its own coefficient set. Addresses come
        // mostly from a small pool so pixel state builds up, with one hot
        // address to provoke read-after-write hazards.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                1: program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                2: program_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
                3: program_coefs(18'sd1024, 18'sd2048, 18'sd1024, -18'sd26000, 18'sd10500);
                default: program_coefs(pick_coef(), pick_coef(), pick_coef(),
                                       pick_coef(), pick_coef());
            endcase
            steady = (p == 3);
            foreach (pool[i]) pool[i] = PIXEL_ADDR_W'($urandom);
            pool[1] = '0;
            pool[2] = '1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Drain fully once mid-phase with state still live.
                if (p == 4 && n == PHASE_ITEMS / 2) settle();
                roll = $urandom_range(99);
                if (roll < 20) addr = pool[0];
                else if (roll < 90) addr = pool[$urandom_range(7)];
                else addr = PIXEL_ADDR_W'($urandom);
                send_pixel(($urandom_range(99) < 8) ? OP_CLEAR : OP_FILTER,
                           addr, pick_diff(), pick_diff());
            end
            steady = 1'b0;
        end

        // Pin one pixel at full-scale differences, each transaction after the first
        // held by the address interlock, then reverse the direction.
        settle();
        program_coefs(COEF_B0_RESET, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        steady = 1'b1;
        send_pixel(OP_CLEAR, PIN_ADDR, '0, '0);
        repeat (PIN_STEPS) send_pixel(OP_FILTER, PIN_ADDR, 16'sh7FFF, 16'sh8000);
        repeat (4) send_pixel(OP_FILTER, PIN_ADDR, 16'sh8000, 16'sh7FFF);
        steady = 1'b0;

        settle();
        $display("Checked %0d results from %0d transactions (%0d clears), %0d coef sets,",
                 tracker.matched, sent, clears, settings);
        $display("with unstable extremes and a %0d-step full-scale run on one pixel.",
                 PIN_STEPS);
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
